@@ hw/rtl/flpte_pkg.sv @@
// Types, codes and helpers shared by the page table engine.
package flpte_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_DONE
  } state_t;

  localparam logic [1:0] REQ_MAP       = 2'd0;
  localparam logic [1:0] REQ_TRANSLATE = 2'd1;
  localparam logic [1:0] REQ_UNMAP     = 2'd2;
  localparam logic [1:0] REQ_UPDATE    = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MAPPED     = 2'd1;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd2;
  localparam logic [1:0] ST_NO_PAGES   = 2'd3;

  localparam logic [2:0] CFG_DESC_FLAGS  = 3'd0;
  localparam logic [2:0] CFG_KERN_FLAGS  = 3'd1;
  localparam logic [2:0] CFG_USER_FLAGS  = 3'd2;
  localparam logic [2:0] CFG_USER_MASK   = 3'd3;
  localparam logic [2:0] CFG_REGION_BASE = 3'd4;

  localparam int IDX_W = 9;

  // Table index for a walk level: bits 47:39, 38:30, 29:21 and 20:12.
  function automatic logic [IDX_W-1:0] level_idx(input logic [47:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    r = '0;
    unique case (lvl)
      2'd0: r = va[47:39];
      2'd1: r = va[38:30];
      2'd2: r = va[29:21];
      2'd3: r = va[20:12];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/four_level_page_table_engine_core.sv @@
// Four-level page table engine for 4 KiB pages, with its table memory.
//
// The engine holds TABLE_PAGES table pages of 512 64-bit entries in a single
// synchronous memory with a registered read port; page zero is the root and
// further pages are handed out in order. After reset it first sweeps the whole
// memory to zero, one entry a cycle, before the first request transaction is
// taken; configuration writes are accepted throughout. Requests are handled one
// at a time. A request is accepted, then read and evaluated at each level for
// up to four levels, and then its result is presented. Each table page that a
// map request creates adds a sweep that zeroes its 512 entries and a write of
// its descriptor; the worst map creates three levels. The result register
// lets the next request be accepted while the previous result still waits on
// out_ready.
module four_level_page_table_engine_core
  import flpte_pkg::*;
#(
  parameter int TABLE_PAGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [47:0] vaddr,
  input  logic [47:0] paddr,
  input  logic [7:0]  attrib,
  input  logic [63:0] new_flags,
  input  logic        free_frame,
  input  logic        last_page,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] frame_addr,
  output logic        frame_to_free,
  output logic        run_done
);

  localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = TABLE_PAGES * 512;

  // Configuration registers.
  logic [11:0] table_desc_flags, leaf_kernel_flags, leaf_user_flags;
  logic [7:0]  user_access_mask;
  logic [47:0] table_region_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_desc_flags  <= 12'd1027;
      leaf_kernel_flags <= 12'd1795;
      leaf_user_flags   <= 12'd1795;
      user_access_mask  <= 8'd64;
      table_region_base <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DESC_FLAGS:  table_desc_flags  <= cfg_wr_data[11:0];
        CFG_KERN_FLAGS:  leaf_kernel_flags <= cfg_wr_data[11:0];
        CFG_USER_FLAGS:  leaf_user_flags   <= cfg_wr_data[11:0];
        CFG_USER_MASK:   user_access_mask  <= cfg_wr_data[7:0];
        CFG_REGION_BASE: table_region_base <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Table memory: one write port and one registered read port.
  logic [63:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // Control and request registers.
  state_t        state, state_next;
  logic [AW-1:0] clr_cnt;
  logic [IDX_W-1:0] zero_cnt;
  logic [1:0]    lvl;
  logic [PW-1:0] pg;
  logic [PW:0]   next_free;
  logic [AW-1:0] link_addr;
  logic [63:0]   link_data;

  logic [1:0]  r_type;
  logic [47:0] r_va, r_pa;
  logic [7:0]  r_attrib;
  logic [63:0] r_flags;
  logic        r_free, r_last;

  logic [1:0]  res_status;
  logic [63:0] res_frame;
  logic        res_free;

  // Combinational decode of the word just read.
  logic [63:0] rd;
  logic [51:0] diff, new_base;
  logic        in_region, pages_left;
  logic [AW-1:0] cur_addr;
  logic [11:0] base_bits;
  logic        out_load;

  assign rd         = mem_rdata;
  assign diff       = rd[63:12] - {16'b0, table_region_base[47:12]};
  assign in_region  = diff < 52'(TABLE_PAGES);
  assign pages_left = next_free < (PW+1)'(TABLE_PAGES);
  assign new_base   = {16'b0, table_region_base[47:12]} + 52'(next_free);
  assign cur_addr   = {pg, level_idx(r_va, lvl)};
  assign base_bits  = ((r_attrib & user_access_mask) != 8'd0) ? leaf_user_flags
                                                               : leaf_kernel_flags;
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);
  assign in_ready   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = '0;
    mem_raddr  = cur_addr;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        if (clr_cnt == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) state_next = S_READ;
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        state_next = S_DONE;
        if (lvl != 2'd3) begin
          if (rd[0] && in_region) state_next = S_READ;
          else if (!rd[0] && r_type == REQ_MAP && pages_left) state_next = S_ZERO;
        end else if (r_type == REQ_MAP) begin
          if (!rd[0]) begin
            mem_we    = 1'b1;
            mem_wdata = {16'b0, r_pa[47:12], 12'b0} | {52'b0, base_bits}
                        | {56'b0, r_attrib};
          end
        end else if (rd[0]) begin
          if (r_type == REQ_UNMAP) begin
            mem_we = 1'b1;
          end else if (r_type == REQ_UPDATE) begin
            mem_we    = 1'b1;
            mem_wdata = {rd[63:12], 12'b0} | r_flags;
          end
        end
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = {pg, zero_cnt};
        if (zero_cnt == IDX_W'(511)) state_next = S_LINK;
      end
      S_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = link_addr;
        mem_wdata  = link_data;
        state_next = S_READ;
      end
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      zero_cnt  <= '0;
      next_free <= (PW+1)'(1);
      out_valid <= 1'b0;
      lvl       <= '0;
      pg        <= '0;
    end else begin
      if (state == S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (state == S_ZERO) zero_cnt <= zero_cnt + IDX_W'(1);
      if (state == S_IDLE && in_valid) begin
        lvl <= '0;
        pg  <= '0;
      end
      if (state == S_LINK) lvl <= lvl + 2'd1;
      if (state == S_EVAL && lvl != 2'd3) begin
        if (rd[0] && in_region) begin
          pg  <= diff[PW-1:0];
          lvl <= lvl + 2'd1;
        end else if (!rd[0] && r_type == REQ_MAP && pages_left) begin
          pg        <= next_free[PW-1:0];
          next_free <= next_free + (PW+1)'(1);
          zero_cnt  <= '0;
        end
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      r_type   <= req_type;
      r_va     <= vaddr;
      r_pa     <= paddr;
      r_attrib <= attrib;
      r_flags  <= new_flags;
      r_free   <= free_frame;
      r_last   <= last_page;
    end
    if (state == S_EVAL) begin
      link_addr <= cur_addr;
      link_data <= {new_base, 12'b0} | {52'b0, table_desc_flags};
      res_frame <= '0;
      res_free  <= 1'b0;
      if (lvl != 2'd3) begin
        res_status <= (r_type == REQ_MAP) ? ST_NO_PAGES : ST_NOT_MAPPED;
      end else if (r_type == REQ_MAP) begin
        res_status <= rd[0] ? ST_MAPPED : ST_OK;
        if (rd[0]) res_frame <= {rd[63:12], 12'b0};
      end else if (rd[0]) begin
        res_status <= ST_OK;
        res_frame  <= {rd[63:12], 12'b0};
        res_free   <= (r_type == REQ_UNMAP) && r_free && (rd[63:12] != 52'd0);
      end else begin
        res_status <= ST_NOT_MAPPED;
      end
    end
    if (out_load) begin
      status        <= res_status;
      frame_addr    <= res_frame;
      frame_to_free <= res_free;
      run_done      <= r_last;
    end
  end

  // Table pages are never handed out beyond the region.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= (PW+1)'(TABLE_PAGES))
    else $error("table page counter overran the region");

  // An accepted request always starts with a read of the root level.
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_READ && lvl == 2'd0 && pg == '0)
    else $error("request did not start at the root");

  // A result is only loaded when the output register is free or draining.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$past(out_load))
    else $error("result overwrote a pending transaction");

  // Creating a level always consumes a table page.
  a_alloc: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL && state_next == S_ZERO |=> next_free == $past(next_free) + 1'b1)
    else $error("new level without page allocation");

endmodule
